// ----- hdl/vsoc_pkg.sv -----
// Shared types, constants and saturation helpers for the visual servo observer controller.
`timescale 1ns / 1ps
`default_nettype none
package vsoc_pkg;

    localparam int VALUE_BITS = 32;
    localparam int WB         = ((VALUE_BITS > 32) ? VALUE_BITS : 32) + 2;
    localparam int CW         = 20;               // multiplier coefficient bits
    localparam int CNT_W      = $clog2(CW);
    localparam int GAIN_BITS  = 12;
    localparam int CFG_BITS   = 60;
    localparam int FEAT_BITS  = 32;
    localparam int OUT_BITS   = 32;
    localparam int HG_BITS    = 16;
    localparam int SH_GAIN_N  = 6;
    localparam int SH_YAW_N   = 12;
    localparam int SH_DT_N    = 20;

    typedef logic signed [VALUE_BITS-1:0] val_t;
    typedef logic signed [VALUE_BITS:0]   tval_t;
    typedef logic signed [WB-1:0]         wide_t;
    typedef logic signed [FEAT_BITS-1:0]  feat_t;
    typedef logic signed [OUT_BITS-1:0]   out_t;

    localparam wide_t W_MAX = {{(WB-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
    localparam wide_t W_MIN = {{(WB-VALUE_BITS+1){1'b1}}, {(VALUE_BITS-1){1'b0}}};
    localparam wide_t O_MAX = wide_t'(32'sh7fff_ffff);
    localparam wide_t O_MIN = wide_t'(32'sh8000_0000);
    localparam val_t  ONE_Q16   = val_t'(65536);
    localparam feat_t YAW_LIMIT = 32'sd26214;

    localparam logic CMD_FRAME   = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    typedef enum logic [1:0] {
        REG_GAINS_X      = 2'd0,
        REG_GAINS_Y      = 2'd1,
        REG_GAINS_Z      = 2'd2,
        REG_HEADING_GAIN = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        SH_GAIN,
        SH_YAW,
        SH_DT
    } shift_t;

    typedef struct packed {
        logic   start;
        shift_t sh;
    } mul_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AXIS,
        ST_TILDE,
        ST_LTIL,
        ST_POS,
        ST_LD,
        ST_RATE,
        ST_ALPHA,
        ST_INTEG,
        ST_G1,
        ST_G2,
        ST_DRIVE,
        ST_YAW,
        ST_DONE
    } vsoc_state_t;

    function automatic val_t sat_w(wide_t x);
        val_t r;
        if (x > W_MAX) begin
            r = W_MAX[VALUE_BITS-1:0];
        end else if (x < W_MIN) begin
            r = W_MIN[VALUE_BITS-1:0];
        end else begin
            r = x[VALUE_BITS-1:0];
        end
        return r;
    endfunction

    function automatic wide_t ext_v(val_t v);
        return wide_t'(v);
    endfunction

    function automatic wide_t ext_f(feat_t f);
        return wide_t'(f);
    endfunction

    function automatic out_t out32(val_t v);
        wide_t w;
        out_t  r;
        w = wide_t'(v);
        if (w > O_MAX) begin
            r = O_MAX[OUT_BITS-1:0];
        end else if (w < O_MIN) begin
            r = O_MIN[OUT_BITS-1:0];
        end else begin
            r = w[OUT_BITS-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/vsoc_mul.sv -----
// Bit-serial sign-magnitude multiplier with truncating shift and saturation.
`timescale 1ns / 1ps
`default_nettype none
module vsoc_mul (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire vsoc_pkg::mul_ctl_t         ctl,
    input  wire vsoc_pkg::val_t             v,
    input  wire logic [vsoc_pkg::CW-1:0]    c,
    output logic                            done,
    output vsoc_pkg::val_t                  res
);

    localparam int VB = vsoc_pkg::VALUE_BITS;
    localparam int CW = vsoc_pkg::CW;

    logic                          busy_reg, fin_reg;
    logic [vsoc_pkg::CNT_W-1:0]    cnt_reg;
    logic                          neg_reg;
    vsoc_pkg::shift_t              sh_reg;
    logic [VB-1:0]                 m_reg, hi_reg;
    logic [CW-1:0]                 c_reg, lo_reg;
    logic [VB:0]                   sum;
    logic [VB-1:0]                 mag;
    logic                          last_step;
    logic [VB+CW-1:0]              prod, r;
    logic                          pos_ovf, neg_ovf;

    assign last_step = (cnt_reg == vsoc_pkg::CNT_W'(CW - 1));
    assign mag       = v[VB-1] ? (~v + 1'b1) : v;
    assign sum       = {1'b0, hi_reg} + (c_reg[0] ? {1'b0, m_reg} : '0);
    assign prod      = {hi_reg, lo_reg};

    always_comb begin
        case (sh_reg)
            vsoc_pkg::SH_GAIN: r = prod >> vsoc_pkg::SH_GAIN_N;
            vsoc_pkg::SH_YAW:  r = prod >> vsoc_pkg::SH_YAW_N;
            vsoc_pkg::SH_DT:   r = prod >> vsoc_pkg::SH_DT_N;
            default:           r = prod;
        endcase
        pos_ovf = |r[VB+CW-1:VB-1];
        neg_ovf = (|r[VB+CW-1:VB]) || (r[VB-1] && (|r[VB-2:0]));
        if (neg_reg) begin
            res = neg_ovf ? vsoc_pkg::W_MIN[VB-1:0] : -$signed(r[VB-1:0]);
        end else begin
            res = pos_ovf ? vsoc_pkg::W_MAX[VB-1:0] : $signed(r[VB-1:0]);
        end
    end

    assign done = fin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            fin_reg <= busy_reg && last_step;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            neg_reg <= v[VB-1];
            m_reg   <= mag;
            c_reg   <= c;
            hi_reg  <= '0;
            lo_reg  <= '0;
            sh_reg  <= ctl.sh;
        end else if (busy_reg) begin
            hi_reg <= sum[VB:1];
            lo_reg <= {sum[0], lo_reg[CW-1:1]};
            c_reg  <= c_reg >> 1;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/vsoc_seq.sv -----
// Sequencer and state for the three axis observers and the yaw setpoint.
`timescale 1ns / 1ps
`default_nettype none
module vsoc_seq (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic                              cmd,
    input  wire vsoc_pkg::feat_t                   feature_x,
    input  wire vsoc_pkg::feat_t                   feature_y,
    input  wire vsoc_pkg::feat_t                   feature_z,
    input  wire vsoc_pkg::feat_t                   feature_yaw,
    input  wire logic [3:0]                        feature_valid,
    input  wire logic                              servo_enabled,
    input  wire logic [19:0]                       step_seconds,
    input  wire vsoc_pkg::feat_t                   heading_now,
    input  wire logic [vsoc_pkg::CFG_BITS-1:0]     gains_x,
    input  wire logic [vsoc_pkg::CFG_BITS-1:0]     gains_y,
    input  wire logic [vsoc_pkg::CFG_BITS-1:0]     gains_z,
    input  wire logic signed [vsoc_pkg::HG_BITS-1:0] heading_gain,
    input  wire logic                              out_free,
    output logic                                   idle,
    output logic                                   done,
    output vsoc_pkg::out_t                         pitch_cmd,
    output vsoc_pkg::out_t                         roll_cmd,
    output vsoc_pkg::out_t                         thrust_cmd,
    output vsoc_pkg::out_t                         yaw_cmd,
    output logic [3:0]                             setpoint_valid,
    output logic [2:0]                             observer_valid,
    output vsoc_pkg::mul_ctl_t                     mul_ctl,
    output vsoc_pkg::val_t                         mul_v,
    output logic [vsoc_pkg::CW-1:0]                mul_c,
    input  wire logic                              mul_done,
    input  wire vsoc_pkg::val_t                    mul_res
);

    vsoc_pkg::vsoc_state_t state_reg, state_next;
    logic [1:0]            ax_reg, ax_next;
    logic                  wait_reg, wait_next;
    logic                  frame_reg, frame_next;
    logic [2:0]            pend_reg, pend_next;

    vsoc_pkg::val_t pos_reg[3], pos_next[3];
    vsoc_pkg::val_t rate_reg[3], rate_next[3];
    vsoc_pkg::val_t integ_reg[3], integ_next[3];
    vsoc_pkg::val_t last_reg[4], last_next[4];

    vsoc_pkg::val_t  e_reg, e_next, tilde_reg, tilde_next, ltil_reg, ltil_next;
    vsoc_pkg::val_t  tmp_reg, tmp_next, al_reg, al_next;
    vsoc_pkg::tval_t term_reg, term_next;

    vsoc_pkg::feat_t fx_reg, fy_reg, fz_reg, fyaw_reg, head_reg;
    logic [3:0]      valid_reg;
    logic [19:0]     dt_reg;

    logic [vsoc_pkg::CFG_BITS-1:0] g;
    logic [vsoc_pkg::GAIN_BITS-1:0] gl, gld, ggam, gk, gal;
    logic                           roll, mul_state;
    vsoc_pkg::feat_t                f_sel, a_yaw;
    vsoc_pkg::val_t                 f_sat, e_calc, pos_cur, rate_cur, integ_cur, t_sat;
    vsoc_pkg::tval_t                d_sgn;
    logic signed [vsoc_pkg::HG_BITS:0] hg_w, hg_mag;
    vsoc_pkg::wide_t                yaw_add;

    always_comb begin
        case (ax_reg)
            2'd0:    begin g = gains_x; f_sel = fx_reg; end
            2'd1:    begin g = gains_y; f_sel = fy_reg; end
            default: begin g = gains_z; f_sel = fz_reg; end
        endcase
        gl   = g[11:0];
        gld  = g[23:12];
        ggam = g[35:24];
        gk   = g[47:36];
        gal  = g[59:48];
        roll = (ax_reg == 2'd1);
        f_sat  = vsoc_pkg::sat_w(vsoc_pkg::ext_f(f_sel));
        // height axis regulates towards a feature value of one
        e_calc = (ax_reg == 2'd2)
               ? vsoc_pkg::sat_w(vsoc_pkg::ext_v(f_sat) - vsoc_pkg::ext_v(vsoc_pkg::ONE_Q16))
               : f_sat;
        pos_cur   = pos_reg[ax_reg];
        rate_cur  = rate_reg[ax_reg];
        integ_cur = integ_reg[ax_reg];
        if (fyaw_reg > vsoc_pkg::YAW_LIMIT) begin
            a_yaw = vsoc_pkg::YAW_LIMIT;
        end else if (fyaw_reg < -vsoc_pkg::YAW_LIMIT) begin
            a_yaw = -vsoc_pkg::YAW_LIMIT;
        end else begin
            a_yaw = fyaw_reg;
        end
        hg_w   = {heading_gain[vsoc_pkg::HG_BITS-1], heading_gain};
        hg_mag = hg_w[vsoc_pkg::HG_BITS] ? -hg_w : hg_w;
        mul_state = state_reg inside {vsoc_pkg::ST_LTIL, vsoc_pkg::ST_POS, vsoc_pkg::ST_LD,
                                      vsoc_pkg::ST_RATE, vsoc_pkg::ST_ALPHA,
                                      vsoc_pkg::ST_INTEG, vsoc_pkg::ST_G1, vsoc_pkg::ST_G2,
                                      vsoc_pkg::ST_DRIVE, vsoc_pkg::ST_YAW};
    end

    always_comb begin
        state_next = state_reg;
        ax_next    = ax_reg;
        wait_next  = wait_reg;
        frame_next = frame_reg;
        pend_next  = pend_reg;
        pos_next   = pos_reg;
        rate_next  = rate_reg;
        integ_next = integ_reg;
        last_next  = last_reg;
        e_next     = e_reg;
        tilde_next = tilde_reg;
        ltil_next  = ltil_reg;
        tmp_next   = tmp_reg;
        al_next    = al_reg;
        term_next  = term_reg;
        mul_ctl    = '0;
        mul_v      = '0;
        mul_c      = '0;
        done       = 1'b0;
        t_sat      = '0;
        d_sgn      = '0;
        yaw_add    = '0;

        case (state_reg)
            vsoc_pkg::ST_IDLE: begin
                if (start) begin
                    ax_next = 2'd0;
                    if (cmd == vsoc_pkg::CMD_FRAME) begin
                        frame_next = 1'b1;
                        if (!servo_enabled) begin
                            pend_next = '1;
                        end
                        state_next = vsoc_pkg::ST_AXIS;
                    end else begin
                        frame_next = 1'b0;
                        state_next = vsoc_pkg::ST_DONE;
                    end
                end
            end
            vsoc_pkg::ST_AXIS: begin
                if (ax_reg == 2'd3) begin
                    if (valid_reg[3]) begin
                        state_next = vsoc_pkg::ST_YAW;
                    end else begin
                        last_next[3] = '0;
                        state_next   = vsoc_pkg::ST_DONE;
                    end
                end else if (valid_reg[ax_reg]) begin
                    e_next     = e_calc;
                    state_next = vsoc_pkg::ST_TILDE;
                end else begin
                    integ_next[ax_reg] = '0;
                    last_next[ax_reg]  = '0;
                    ax_next            = ax_reg + 2'd1;
                end
            end
            vsoc_pkg::ST_TILDE: begin
                tilde_next = vsoc_pkg::sat_w(vsoc_pkg::ext_v(e_reg) - vsoc_pkg::ext_v(pos_cur));
                state_next = vsoc_pkg::ST_LTIL;
            end
            vsoc_pkg::ST_LTIL: begin
                mul_v = tilde_reg;
                mul_c = vsoc_pkg::CW'(gl);
                mul_ctl.sh = vsoc_pkg::SH_GAIN;
                if (mul_done) begin
                    ltil_next  = mul_res;
                    state_next = vsoc_pkg::ST_POS;
                end
            end
            vsoc_pkg::ST_POS: begin
                mul_v = vsoc_pkg::sat_w(vsoc_pkg::ext_v(ltil_reg) - vsoc_pkg::ext_v(rate_cur));
                mul_c = dt_reg;
                mul_ctl.sh = vsoc_pkg::SH_DT;
                if (mul_done) begin
                    pos_next[ax_reg] = vsoc_pkg::sat_w(vsoc_pkg::ext_v(pos_cur)
                                                       + vsoc_pkg::ext_v(mul_res));
                    state_next = vsoc_pkg::ST_LD;
                end
            end
            vsoc_pkg::ST_LD: begin
                mul_v = ltil_reg;
                mul_c = vsoc_pkg::CW'(gld);
                mul_ctl.sh = vsoc_pkg::SH_GAIN;
                if (mul_done) begin
                    tmp_next   = mul_res;
                    state_next = vsoc_pkg::ST_RATE;
                end
            end
            vsoc_pkg::ST_RATE: begin
                mul_v = tmp_reg;
                mul_c = dt_reg;
                mul_ctl.sh = vsoc_pkg::SH_DT;
                if (mul_done) begin
                    rate_next[ax_reg] = vsoc_pkg::sat_w(vsoc_pkg::ext_v(rate_cur)
                                                        - vsoc_pkg::ext_v(mul_res));
                    state_next = vsoc_pkg::ST_ALPHA;
                end
            end
            vsoc_pkg::ST_ALPHA: begin
                mul_v = e_reg;
                mul_c = vsoc_pkg::CW'(gal);
                mul_ctl.sh = vsoc_pkg::SH_GAIN;
                if (mul_done) begin
                    al_next = mul_res;
                    if (pend_reg[ax_reg]) begin
                        // first frame after a restart: integral and its term start at zero
                        integ_next[ax_reg] = '0;
                        term_next          = '0;
                        pend_next[ax_reg]  = 1'b0;
                        state_next         = vsoc_pkg::ST_DRIVE;
                    end else begin
                        state_next = vsoc_pkg::ST_INTEG;
                    end
                end
            end
            vsoc_pkg::ST_INTEG: begin
                mul_v = al_reg;
                mul_c = dt_reg;
                mul_ctl.sh = vsoc_pkg::SH_DT;
                if (mul_done) begin
                    integ_next[ax_reg] = vsoc_pkg::sat_w(vsoc_pkg::ext_v(integ_cur)
                                                         + vsoc_pkg::ext_v(mul_res));
                    state_next = vsoc_pkg::ST_G1;
                end
            end
            vsoc_pkg::ST_G1: begin
                mul_v = e_reg;
                mul_c = vsoc_pkg::CW'(ggam);
                mul_ctl.sh = vsoc_pkg::SH_GAIN;
                if (mul_done) begin
                    tmp_next   = mul_res;
                    state_next = vsoc_pkg::ST_G2;
                end
            end
            vsoc_pkg::ST_G2: begin
                mul_v = integ_cur;
                mul_c = vsoc_pkg::CW'(ggam);
                mul_ctl.sh = vsoc_pkg::SH_GAIN;
                if (mul_done) begin
                    t_sat = vsoc_pkg::sat_w(vsoc_pkg::ext_v(tmp_reg) + vsoc_pkg::ext_v(mul_res));
                    term_next  = roll ? vsoc_pkg::tval_t'(t_sat) : -vsoc_pkg::tval_t'(t_sat);
                    state_next = vsoc_pkg::ST_DRIVE;
                end
            end
            vsoc_pkg::ST_DRIVE: begin
                mul_v = vsoc_pkg::sat_w(vsoc_pkg::ext_v(rate_cur) - vsoc_pkg::ext_v(al_reg));
                mul_c = vsoc_pkg::CW'(gk);
                mul_ctl.sh = vsoc_pkg::SH_GAIN;
                if (mul_done) begin
                    d_sgn = roll ? -vsoc_pkg::tval_t'(mul_res) : vsoc_pkg::tval_t'(mul_res);
                    last_next[ax_reg] = vsoc_pkg::sat_w(vsoc_pkg::wide_t'(d_sgn)
                                                        + vsoc_pkg::wide_t'(term_reg));
                    ax_next    = ax_reg + 2'd1;
                    state_next = vsoc_pkg::ST_AXIS;
                end
            end
            vsoc_pkg::ST_YAW: begin
                mul_v = vsoc_pkg::val_t'(a_yaw);
                mul_c = vsoc_pkg::CW'(unsigned'(hg_mag));
                mul_ctl.sh = vsoc_pkg::SH_YAW;
                if (mul_done) begin
                    yaw_add = heading_gain[vsoc_pkg::HG_BITS-1] ? -vsoc_pkg::ext_v(mul_res)
                                                                : vsoc_pkg::ext_v(mul_res);
                    last_next[3] = vsoc_pkg::sat_w(
                        vsoc_pkg::ext_v(vsoc_pkg::sat_w(vsoc_pkg::ext_f(head_reg))) + yaw_add);
                    state_next = vsoc_pkg::ST_DONE;
                end
            end
            vsoc_pkg::ST_DONE: begin
                done = 1'b1;
                if (out_free) begin
                    state_next = vsoc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = vsoc_pkg::ST_IDLE;
            end
        endcase

        if (mul_state) begin
            if (!wait_reg) begin
                mul_ctl.start = 1'b1;
                wait_next     = 1'b1;
            end else if (mul_done) begin
                wait_next = 1'b0;
            end
        end
    end

    assign idle           = (state_reg == vsoc_pkg::ST_IDLE);
    assign pitch_cmd      = vsoc_pkg::out32(last_reg[0]);
    assign roll_cmd       = vsoc_pkg::out32(last_reg[1]);
    assign thrust_cmd     = vsoc_pkg::out32(last_reg[2]);
    assign yaw_cmd        = vsoc_pkg::out32(last_reg[3]);
    assign setpoint_valid = frame_reg ? {valid_reg[3], valid_reg[2], valid_reg[0], valid_reg[1]}
                                      : 4'd0;
    assign observer_valid = (frame_reg && valid_reg[2]) ? {1'b1, valid_reg[0], valid_reg[1]}
                                                        : 3'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vsoc_pkg::ST_IDLE;
            ax_reg    <= '0;
            wait_reg  <= 1'b0;
            frame_reg <= 1'b0;
            pend_reg  <= '1;
            for (int i = 0; i < 3; i++) begin
                pos_reg[i]   <= '0;
                rate_reg[i]  <= '0;
                integ_reg[i] <= '0;
            end
            for (int i = 0; i < 4; i++) begin
                last_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            ax_reg    <= ax_next;
            wait_reg  <= wait_next;
            frame_reg <= frame_next;
            pend_reg  <= pend_next;
            pos_reg   <= pos_next;
            rate_reg  <= rate_next;
            integ_reg <= integ_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        e_reg     <= e_next;
        tilde_reg <= tilde_next;
        ltil_reg  <= ltil_next;
        tmp_reg   <= tmp_next;
        al_reg    <= al_next;
        term_reg  <= term_next;
        if (idle && start) begin
            fx_reg    <= feature_x;
            fy_reg    <= feature_y;
            fz_reg    <= feature_z;
            fyaw_reg  <= feature_yaw;
            head_reg  <= heading_now;
            valid_reg <= feature_valid;
            dt_reg    <= step_seconds;
        end
    end

    a_mul_done_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> mul_state && wait_reg)
        else $error("multiplier finished outside a multiply step");

    a_single_start: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_ctl.start |=> !mul_ctl.start)
        else $error("multiplier restarted while busy");

    a_timeout_masks: assert property (@(posedge aclk) disable iff (!aresetn)
        (done && !frame_reg) |-> (setpoint_valid == 4'd0 && observer_valid == 3'd0))
        else $error("timeout result carries valid bits");

    a_z_gates_obs: assert property (@(posedge aclk) disable iff (!aresetn)
        (observer_valid != 3'd0) |-> observer_valid[2])
        else $error("observer mask set without height observer");

endmodule
`default_nettype wire

// ----- hdl/visual_servo_observer_controller.sv -----
// Top level: configuration registers, input/output handshakes, sequencer and multiplier.
`timescale 1ns / 1ps
`default_nettype none
// Sequence: a timeout tick goes straight to the done state; a frame tick visits each axis
//   in turn, skipping an invalid one, and runs 6 multiplies per valid axis on a restart
//   frame and 9 otherwise, then one yaw multiply if yaw is valid. The result is loaded
//   into the output register once that register is free.
// Flow: one item at a time; the bit-serial multiplier, shared by all axes and yaw,
//   works through 20 coefficient bits per multiply.
// Reset (aresetn low, synchronous): gains, heading gain, observers, integrals and last
//   setpoints go to zero and every axis is marked to restart its integral.
module visual_servo_observer_controller (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration writes
    input  wire logic                                cfg_wr_en,
    input  wire logic [1:0]                          cfg_index,
    input  wire logic [vsoc_pkg::CFG_BITS-1:0]       cfg_wr_data,
    // input channel
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_cmd,
    input  wire logic signed [31:0]                  s_feature_x,
    input  wire logic signed [31:0]                  s_feature_y,
    input  wire logic signed [31:0]                  s_feature_z,
    input  wire logic signed [31:0]                  s_feature_yaw,
    input  wire logic [3:0]                          s_feature_valid,
    input  wire logic                                s_servo_enabled,
    input  wire logic [19:0]                         s_step_seconds,
    input  wire logic signed [31:0]                  s_heading_now,
    // result channel
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [31:0]                       m_pitch_cmd,
    output logic signed [31:0]                       m_roll_cmd,
    output logic signed [31:0]                       m_thrust_cmd,
    output logic signed [31:0]                       m_yaw_cmd,
    output logic [3:0]                               m_setpoint_valid,
    output logic [2:0]                               m_observer_valid
);

    logic [vsoc_pkg::CFG_BITS-1:0]        gains_x_reg, gains_y_reg, gains_z_reg;
    logic signed [vsoc_pkg::HG_BITS-1:0]  hg_reg;

    logic               m_valid_reg;
    vsoc_pkg::out_t     pitch_reg, roll_reg, thrust_reg, yaw_reg;
    logic [3:0]         sp_reg;
    logic [2:0]         ob_reg;

    logic               seq_idle, seq_done, out_free;
    vsoc_pkg::out_t     seq_pitch, seq_roll, seq_thrust, seq_yaw;
    logic [3:0]         seq_sp;
    logic [2:0]         seq_ob;

    vsoc_pkg::mul_ctl_t          mul_ctl;
    vsoc_pkg::val_t              mul_v, mul_res;
    logic [vsoc_pkg::CW-1:0]     mul_c;
    logic                        mul_done;

    // register writes land straight away; software must write only while the block is idle (not enforced here)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_x_reg <= '0;
            gains_y_reg <= '0;
            gains_z_reg <= '0;
            hg_reg      <= '0;
        end else if (cfg_wr_en) begin
            case (vsoc_pkg::reg_idx_t'(cfg_index))
                vsoc_pkg::REG_GAINS_X:      gains_x_reg <= cfg_wr_data;
                vsoc_pkg::REG_GAINS_Y:      gains_y_reg <= cfg_wr_data;
                vsoc_pkg::REG_GAINS_Z:      gains_z_reg <= cfg_wr_data;
                vsoc_pkg::REG_HEADING_GAIN: hg_reg <= cfg_wr_data[vsoc_pkg::HG_BITS-1:0];
                default:                    hg_reg <= hg_reg;
            endcase
        end
    end

    // input transfer only when the sequencer is idle; the output register keeps the
    // previous result so a new item may start while it waits to be taken
    assign s_ready  = seq_idle;
    assign out_free = !m_valid_reg || m_ready;

    vsoc_seq u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start          (s_valid && s_ready),
        .cmd            (s_cmd),
        .feature_x      (s_feature_x),
        .feature_y      (s_feature_y),
        .feature_z      (s_feature_z),
        .feature_yaw    (s_feature_yaw),
        .feature_valid  (s_feature_valid),
        .servo_enabled  (s_servo_enabled),
        .step_seconds   (s_step_seconds),
        .heading_now    (s_heading_now),
        .gains_x        (gains_x_reg),
        .gains_y        (gains_y_reg),
        .gains_z        (gains_z_reg),
        .heading_gain   (hg_reg),
        .out_free       (out_free),
        .idle           (seq_idle),
        .done           (seq_done),
        .pitch_cmd      (seq_pitch),
        .roll_cmd       (seq_roll),
        .thrust_cmd     (seq_thrust),
        .yaw_cmd        (seq_yaw),
        .setpoint_valid (seq_sp),
        .observer_valid (seq_ob),
        .mul_ctl        (mul_ctl),
        .mul_v          (mul_v),
        .mul_c          (mul_c),
        .mul_done       (mul_done),
        .mul_res        (mul_res)
    );

    vsoc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mul_ctl),
        .v       (mul_v),
        .c       (mul_c),
        .done    (mul_done),
        .res     (mul_res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (seq_done && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (seq_done && out_free) begin
            pitch_reg  <= seq_pitch;
            roll_reg   <= seq_roll;
            thrust_reg <= seq_thrust;
            yaw_reg    <= seq_yaw;
            sp_reg     <= seq_sp;
            ob_reg     <= seq_ob;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_pitch_cmd      = pitch_reg;
    assign m_roll_cmd       = roll_reg;
    assign m_thrust_cmd     = thrust_reg;
    assign m_yaw_cmd        = yaw_reg;
    assign m_setpoint_valid = sp_reg;
    assign m_observer_valid = ob_reg;

endmodule
`default_nettype wire
